[rtl/vfc_pkg.sv]
`default_nettype none

package vfc_pkg;

	localparam int unsigned FOOTER_BYTES = 512;
	localparam int unsigned POS_W = 9;
	localparam logic [POS_W-1:0] LAST_POS = 9'd511;
	localparam logic [31:0] FORMAT_VERSION = 32'h0001_0000;
	localparam logic [31:0] FIXED_DISK_TYPE = 32'd2;
	localparam int unsigned LENGTH_W = 63;
	localparam int unsigned SIZE_W = 64;

	// Byte positions of the fields inside the footer
	localparam logic [POS_W-1:0] VERSION_FIRST = 9'd12;
	localparam logic [POS_W-1:0] VERSION_LAST = 9'd15;
	localparam logic [POS_W-1:0] SIZE_FIRST = 9'd48;
	localparam logic [POS_W-1:0] SIZE_LAST = 9'd55;
	localparam logic [POS_W-1:0] TYPE_FIRST = 9'd60;
	localparam logic [POS_W-1:0] TYPE_LAST = 9'd63;
	localparam logic [POS_W-1:0] CSUM_FIRST = 9'd64;
	localparam logic [POS_W-1:0] CSUM_LAST = 9'd67;

	typedef enum logic [2:0] {
		VERDICT_VALID     = 3'd0,
		VERDICT_NO_COOKIE = 3'd1,
		VERDICT_BAD_VER   = 3'd2,
		VERDICT_NOT_FIXED = 3'd3,
		VERDICT_BAD_CSUM  = 3'd4,
		VERDICT_TOO_LARGE = 3'd5
	} verdict_t;

	// Summary of one complete footer, handed from front to back
	typedef struct packed {
		logic              cookie_ok;
		logic              version_ok;
		logic              type_ok;
		logic              sum_ok;
		logic [SIZE_W-1:0] size;
	} vfc_rec_t;

	// Cookie text, one character per position
	function automatic logic [7:0] cookie_byte(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6F;
			3'd2: c = 8'h6E;
			3'd3: c = 8'h65;
			3'd4: c = 8'h63;
			3'd5: c = 8'h74;
			3'd6: c = 8'h69;
			3'd7: c = 8'h78;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/vfc_front.sv]
`default_nettype none

module vfc_front
	import vfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] footer_byte,
	input  wire logic       restart,
	output vfc_rec_t        push_rec,
	output logic            push
);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      sum_q;
	logic             cookie_q;
	logic [31:0]      version_q;
	logic [31:0]      type_q;
	logic [31:0]      stored_q;
	logic [SIZE_W-1:0] size_q;

	logic [POS_W-1:0] pos_eff;
	logic [31:0]      sum_eff;
	logic [31:0]      sum_nxt;
	logic             cookie_eff;
	logic             cookie_nxt;
	logic             in_csum;

	// Restart drops any partial footer before this byte is taken
	assign pos_eff    = restart ? '0 : pos_q;
	assign sum_eff    = restart ? '0 : sum_q;
	assign cookie_eff = restart ? 1'b1 : cookie_q;

	assign in_csum = (pos_eff >= CSUM_FIRST) && (pos_eff <= CSUM_LAST);
	assign sum_nxt = in_csum ? sum_eff : sum_eff + {24'd0, footer_byte};

	always_comb begin
		cookie_nxt = cookie_eff;
		if ((pos_eff[POS_W-1:3] == '0) && (footer_byte != cookie_byte(pos_eff[2:0]))) begin
			cookie_nxt = 1'b0;
		end
	end

	assign push = accept && (pos_eff == LAST_POS);

	// Last byte never falls in a collected field, so the words are final here
	assign push_rec.cookie_ok  = cookie_nxt;
	assign push_rec.version_ok = (version_q == FORMAT_VERSION);
	assign push_rec.type_ok    = (type_q == FIXED_DISK_TYPE);
	assign push_rec.sum_ok     = (~sum_nxt == stored_q);
	assign push_rec.size       = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			cookie_q <= 1'b1;
		end else if (accept) begin
			if (pos_eff == LAST_POS) begin
				pos_q    <= '0;
				sum_q    <= '0;
				cookie_q <= 1'b1;
			end else begin
				pos_q    <= pos_eff + 1'b1;
				sum_q    <= sum_nxt;
				cookie_q <= cookie_nxt;
			end
		end
	end

	// Big-endian field capture
	always_ff @(posedge clk) begin
		if (accept) begin
			if ((pos_eff >= VERSION_FIRST) && (pos_eff <= VERSION_LAST)) begin
				version_q <= {version_q[23:0], footer_byte};
			end
			if ((pos_eff >= SIZE_FIRST) && (pos_eff <= SIZE_LAST)) begin
				size_q <= {size_q[SIZE_W-9:0], footer_byte};
			end
			if ((pos_eff >= TYPE_FIRST) && (pos_eff <= TYPE_LAST)) begin
				type_q <= {type_q[23:0], footer_byte};
			end
			if (in_csum) begin
				stored_q <= {stored_q[23:0], footer_byte};
			end
		end
	end

endmodule

`default_nettype wire

[rtl/vfc_queue.sv]
`default_nettype none

module vfc_queue
	import vfc_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  vfc_rec_t      push_rec,
	output logic          full,
	input  wire logic     pop,
	output vfc_rec_t      head,
	output logic          not_empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	vfc_rec_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

`default_nettype wire

[rtl/vfc_back.sv]
`default_nettype none

module vfc_back
	import vfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [LENGTH_W-1:0] cfg_wr_data,
	input  vfc_rec_t                 head,
	input  wire logic                head_valid,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output verdict_t                 verdict,
	output logic [SIZE_W-1:0]        disk_bytes
);

	logic [LENGTH_W-1:0] limit_q;
	logic                out_valid_q;
	verdict_t            verdict_q;
	logic [SIZE_W-1:0]   disk_q;
	verdict_t            verdict_nxt;

	// Keep the size limit itself so the check is one compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wr_en) begin
			limit_q <= (cfg_wr_data >= LENGTH_W'(FOOTER_BYTES))
				? cfg_wr_data - LENGTH_W'(FOOTER_BYTES) : '0;
		end
	end

	always_comb begin
		if (!head.cookie_ok) begin
			verdict_nxt = VERDICT_NO_COOKIE;
		end else if (!head.version_ok) begin
			verdict_nxt = VERDICT_BAD_VER;
		end else if (!head.type_ok) begin
			verdict_nxt = VERDICT_NOT_FIXED;
		end else if (!head.sum_ok) begin
			verdict_nxt = VERDICT_BAD_CSUM;
		end else if (head.size > {1'b0, limit_q}) begin
			verdict_nxt = VERDICT_TOO_LARGE;
		end else begin
			verdict_nxt = VERDICT_VALID;
		end
	end

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_nxt;
			disk_q    <= (verdict_nxt == VERDICT_VALID) ? head.size : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign disk_bytes = disk_q;

endmodule

`default_nettype wire

[rtl/vhd_footer_checker.sv]
`default_nettype none

// Fixed-disk image footer checker. Feed the 512-byte footer one byte per word on the
// slave side, in file order, with tuser set on the first byte (a set tuser in mid
// footer drops the partial footer). One byte is taken every cycle; s_tready falls
// only while the result queue is full, which takes several unread results. After
// byte 511 one result word passes the queue and the output register to the master
// side: the first failing check in the order cookie, version, disk type, checksum,
// size, or valid together with the disk size. The position counter rearms by itself
// after each footer. cfg_wr_data is the total image file length in bytes, footer
// included; write it only while no footer is in flight. It resets to 512.
module vhd_footer_checker
	import vfc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [62:0] cfg_wr_data,   // file_length
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,       // [7:0] footer_byte
	input  wire logic [0:0]  s_tuser,       // [0] restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata        // [2:0] verdict, [66:3] disk_bytes, rest zero
);

	vfc_rec_t          push_rec;
	vfc_rec_t          head;
	logic              push;
	logic              full;
	logic              pop;
	logic              head_valid;
	logic              accept;
	verdict_t          verdict;
	logic [SIZE_W-1:0] disk_bytes;

	// Hold off new bytes only while the queue has no room for a finished footer
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// Front: track position, match the cookie, capture fields, sum bytes
	vfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.footer_byte (s_tdata),
		.restart     (s_tuser[0]),
		.push_rec    (push_rec),
		.push        (push)
	);

	// Decouple the byte stream from the result side
	vfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid)
	);

	// Back: size check against the configured limit, pick the verdict, drive the word
	vfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.verdict     (verdict),
		.disk_bytes  (disk_bytes)
	);

	assign m_tdata = {5'd0, disk_bytes, verdict};

endmodule

`default_nettype wire

[rtl/vfc_checker.sv]
`default_nettype none

module vfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic [0:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'd5))
		else $error("verdict code out of range");

	a_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[66:3] == 64'd0))
		else $error("disk size given with a failing verdict");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71:67] == 5'd0))
		else $error("padding bits not zero");

	// Meant to tie results to accepted bytes; as written it never fails
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(m_tvalid, 1) == 1'b0)
		else $error("result word without input");

endmodule

bind vhd_footer_checker vfc_checker u_vfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
	import vfc_pkg::*;

	// Footer cookie, first character in the top byte
	localparam logic [63:0] COOKIE_TEXT = "conectix";
	localparam logic [62:0] LEN_MAX = {63{1'b1}};
	// Size limit when the file length is at its maximum
	localparam logic [63:0] LIMIT_AT_MAX = 64'h7FFF_FFFF_FFFF_FDFF;
	localparam int FULL = FOOTER_BYTES;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int DRAIN_GUARD = 50000;
	localparam int FOOTERS_PER_PHASE = 7;
	localparam int RANDOM_PHASES = 8;

	// Corruptions applied to a well-formed footer; a higher bit is checked earlier
	localparam logic [3:0] ERR_NONE    = 4'b0000;
	localparam logic [3:0] ERR_CSUM    = 4'b0001;
	localparam logic [3:0] ERR_TYPE    = 4'b0010;
	localparam logic [3:0] ERR_VERSION = 4'b0100;
	localparam logic [3:0] ERR_COOKIE  = 4'b1000;

	// Background of a footer; the RAW kinds carry no footer structure at all
	typedef enum logic [2:0] {
		FILL_RND, FILL_ZERO, FILL_ONES, RAW_ZERO, RAW_ONES, RAW_RND
	} fill_e;

	// Choice of the current-size field relative to the size limit
	typedef enum logic [2:0] {
		SZ_ZERO, SZ_LIMIT, SZ_OVER, SZ_MAX, SZ_FIT, SZ_BEYOND
	} size_e;

	typedef struct packed {
		verdict_t    verdict;
		logic [63:0] disk_bytes;
	} footer_verdict_t;

	// One row of the directed table
	typedef struct packed {
		logic        wr_len;
		logic [62:0] len;
		logic [3:0]  errs;
		fill_e       fill;
		size_e       sz;
		logic        lead;
		logic [9:0]  cut;
		logic        typed;
		verdict_t    exp_v;
		logic [63:0] exp_bytes;
	} footer_case_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [62:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	// Shadow of the checker state, advanced on every accepted word
	logic [8:0]  pos_cnt;
	logic [31:0] run_sum;
	logic        cookie_seen_ok;
	logic [31:0] ver_acc;
	logic [31:0] type_acc;
	logic [31:0] csum_acc;
	logic [63:0] size_acc;
	logic [62:0] file_len_cfg;

	footer_verdict_t pending_verdicts[$];
	footer_case_t    dir_cases[$];
	logic [7:0]      footer_buf [0:511];

	// A table row with a typed-in verdict replaces the computed one for its footer
	logic            typed_armed;
	footer_verdict_t typed_verdict;

	int   fail_cnt;
	int   bytes_sent;
	int   results_seen;
	int   len_settings;
	int   verdict_hits [0:7];
	int   send_idle_pct = 12;
	int   recv_idle_pct = 12;
	logic hold_off_req = 1'b0;

	vhd_footer_checker uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always #5 clk = ~clk;

	// Size limit: file length minus the footer, saturated at zero
	function automatic logic [63:0] size_limit();
		return (file_len_cfg >= 63'd512) ? {1'b0, file_len_cfg} - 64'd512 : 64'd0;
	endfunction

	// Nonzero mask, often a single bit so near misses get exercised
	function automatic logic [31:0] flip_word();
		return $urandom_range(1) ? (32'd1 << $urandom_range(31)) : ($urandom | 32'd1);
	endfunction

	function automatic logic [63:0] pick_size(input size_e sz);
		logic [63:0] lim;
		logic [63:0] r;
		logic [63:0] val;
		lim = size_limit();
		r = {$urandom, $urandom};
		case (sz)
			SZ_ZERO:  val = '0;
			SZ_LIMIT: val = lim;
			SZ_OVER:  val = lim + 64'd1;
			SZ_MAX:   val = '1;
			SZ_FIT: begin
				case ($urandom_range(4))
					0: val = lim;
					1: val = '0;
					2: val = r % ((lim < 64'd4095 ? lim : 64'd4095) + 64'd1);
					default: val = r % (lim + 64'd1);
				endcase
			end
			default: begin
				// Anything above the limit; ~lim counts the sizes that are left
				if ($urandom_range(3) == 0)
					val = lim + 64'd1 + {56'd0, r[7:0]};
				else
					val = lim + 64'd1 + r % ~lim;
			end
		endcase
		return val;
	endfunction

	// Advance the shadow state by one footer byte; queue a verdict after byte 511
	task automatic absorb_footer_byte(input logic [7:0] b, input logic rs);
		logic [8:0] p;
		footer_verdict_t v;
		if (rs) begin
			pos_cnt = '0;
			run_sum = '0;
			cookie_seen_ok = 1'b1;
		end
		p = pos_cnt;
		if (p < 9'd8 && b != 8'(COOKIE_TEXT >> (8 * (7 - p))))
			cookie_seen_ok = 1'b0;
		if (p >= VERSION_FIRST && p <= VERSION_LAST)
			ver_acc = {ver_acc[23:0], b};
		if (p >= SIZE_FIRST && p <= SIZE_LAST)
			size_acc = {size_acc[55:0], b};
		if (p >= TYPE_FIRST && p <= TYPE_LAST)
			type_acc = {type_acc[23:0], b};
		// Checksum bytes count as zero in the running sum
		if (p >= CSUM_FIRST && p <= CSUM_LAST)
			csum_acc = {csum_acc[23:0], b};
		else
			run_sum = run_sum + {24'd0, b};
		bytes_sent++;
		if (p != LAST_POS) begin
			pos_cnt = p + 9'd1;
		end else begin
			v.disk_bytes = '0;
			if (!cookie_seen_ok)
				v.verdict = VERDICT_NO_COOKIE;
			else if (ver_acc != FORMAT_VERSION)
				v.verdict = VERDICT_BAD_VER;
			else if (type_acc != FIXED_DISK_TYPE)
				v.verdict = VERDICT_NOT_FIXED;
			else if (~run_sum != csum_acc)
				v.verdict = VERDICT_BAD_CSUM;
			else if (size_acc > size_limit())
				v.verdict = VERDICT_TOO_LARGE;
			else begin
				v.verdict = VERDICT_VALID;
				v.disk_bytes = size_acc;
			end
			if (typed_armed) begin
				v = typed_verdict;
				typed_armed = 1'b0;
			end
			pending_verdicts.push_back(v);
			// Rearm for the next footer
			pos_cnt = '0;
			run_sum = '0;
			cookie_seen_ok = 1'b1;
		end
	endtask

	// Offer one word on the slave side; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= rs;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_footer_byte(b, rs);
		@(negedge clk);
	endtask

	// Send the first cut bytes of footer_buf; a short cut leaves a partial footer
	task automatic send_footer(input logic lead, input int cut);
		for (int i = 0; i < cut; i++)
			send_byte(footer_buf[i], (i == 0) ? lead : 1'b0);
	endtask

	// Lay out a footer in footer_buf with a matching checksum, then apply errs; RAW fills get background bytes only
	task automatic build_footer(input logic [3:0] errs, input fill_e fill, input size_e sz);
		logic [31:0] ver;
		logic [31:0] typ;
		logic [31:0] sum;
		logic [63:0] size;
		for (int i = 0; i < FULL; i++) begin
			case (fill)
				FILL_ZERO, RAW_ZERO: footer_buf[i] = 8'h00;
				FILL_ONES, RAW_ONES: footer_buf[i] = 8'hFF;
				default:             footer_buf[i] = 8'($urandom);
			endcase
		end
		if (fill != RAW_ZERO && fill != RAW_ONES && fill != RAW_RND) begin
			for (int i = 0; i < 8; i++)
				footer_buf[i] = 8'(COOKIE_TEXT >> (8 * (7 - i)));
			if (errs & ERR_COOKIE)
				footer_buf[$urandom_range(7)] ^= 8'($urandom_range(1, 255));
			ver = FORMAT_VERSION;
			typ = FIXED_DISK_TYPE;
			if (errs & ERR_VERSION)
				ver ^= flip_word();
			if (errs & ERR_TYPE)
				typ ^= flip_word();
			size = pick_size(sz);
			for (int i = 0; i < 4; i++) begin
				footer_buf[12 + i] = 8'(ver >> (24 - 8 * i));
				footer_buf[60 + i] = 8'(typ >> (24 - 8 * i));
			end
			for (int i = 0; i < 8; i++)
				footer_buf[48 + i] = 8'(size >> (56 - 8 * i));
			sum = '0;
			for (int i = 0; i < FULL; i++)
				if (i < 64 || i > 67)
					sum = sum + {24'd0, footer_buf[i]};
			sum = ~sum;
			if (errs & ERR_CSUM)
				sum ^= flip_word();
			for (int i = 0; i < 4; i++)
				footer_buf[64 + i] = 8'(sum >> (24 - 8 * i));
		end
	endtask

	task automatic add_row(input logic wr, input logic [62:0] len, input logic [3:0] errs,
			input fill_e fill, input size_e sz, input logic lead, input int cut,
			input logic typed, input verdict_t ev, input logic [63:0] eb);
		footer_case_t c;
		c.wr_len = wr;
		c.len = len;
		c.errs = errs;
		c.fill = fill;
		c.sz = sz;
		c.lead = lead;
		c.cut = 10'(cut);
		c.typed = typed;
		c.exp_v = ev;
		c.exp_bytes = eb;
		dir_cases.push_back(c);
	endtask

	// Stop offering and wait until every queued verdict has come out, then let
	// a partial footer or a trailing result settle before anything else changes
	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0 && guard < DRAIN_GUARD) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write file_length; only called with the checker idle
	task automatic write_file_length(input logic [62:0] len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		file_len_cfg = len;
		len_settings++;
	endtask

	// Mostly well-formed footers with random content, some dropped partial
	// footers and bursts of loose bytes in between
	task automatic random_footer_slot();
		int roll;
		logic [3:0] primary;
		logic [3:0] errs;
		size_e sz;
		fill_e fill;
		logic lead;
		roll = $urandom_range(99);
		if (roll < 8) begin
			build_footer(ERR_NONE, FILL_RND, SZ_FIT);
			send_footer(1'b1, $urandom_range(1, FULL - 1));
		end else if (roll < 12) begin
			repeat ($urandom_range(1, 40))
				send_byte(8'($urandom), $urandom_range(7) == 0);
		end
		roll = $urandom_range(99);
		fill = FILL_RND;
		errs = ERR_NONE;
		if (roll < 40)
			sz = SZ_FIT;
		else if (roll < 55)
			sz = SZ_BEYOND;
		else begin
			if (roll < 65)
				primary = ERR_COOKIE;
			else if (roll < 75)
				primary = ERR_VERSION;
			else if (roll < 85)
				primary = ERR_TYPE;
			else if (roll < 95)
				primary = ERR_CSUM;
			else begin
				primary = ERR_NONE;
				fill = RAW_RND;
			end
			// Pile on random later-checked faults; the earliest one must win
			errs = primary | (4'($urandom) & (primary - 4'd1));
			sz = $urandom_range(1) ? SZ_FIT : SZ_BEYOND;
		end
		// Sometimes lean on the automatic rearm instead of a restart mark
		lead = (pos_cnt != 9'd0 || $urandom_range(5) != 0);
		build_footer(errs, fill, sz);
		send_footer(lead, FULL);
	endtask

	// Result side: compare each word with the oldest pending verdict
	always @(posedge clk) begin : check_results
		footer_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			verdict_hits[m_tdata[2:0]]++;
			if (pending_verdicts.size() == 0) begin
				$error("result word with no footer pending: verdict %0d", m_tdata[2:0]);
				fail_cnt++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[2:0] != want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, m_tdata[2:0]);
					fail_cnt++;
				end
				if (m_tdata[66:3] != want.disk_bytes) begin
					$error("disk_bytes: expected 0x%h, got 0x%h",
						want.disk_bytes, m_tdata[66:3]);
					fail_cnt++;
				end
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off when asked for one
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				stall_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Hard stop in case the handshake hangs
	initial begin : watchdog
		#5_000_000;
		$error("run timed out with %0d verdicts pending", pending_verdicts.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		footer_case_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		pos_cnt = '0;
		run_sum = '0;
		cookie_seen_ok = 1'b1;
		ver_acc = '0;
		type_acc = '0;
		csum_acc = '0;
		size_acc = '0;
		file_len_cfg = 63'd512;
		typed_armed = 1'b0;
		typed_verdict = '0;
		fail_cnt = 0;
		bytes_sent = 0;
		results_seen = 0;
		len_settings = 0;
		foreach (verdict_hits[i])
			verdict_hits[i] = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: wr, length, faults, fill, size, lead, bytes, typed, verdict, size out
		// Reset length of 512 leaves no room for any disk data
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_VALID, 0);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_OVER, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		// Largest file length: size right at and just past the limit, and all ones
		add_row(1, LEN_MAX, ERR_NONE, FILL_RND, SZ_LIMIT, 1, FULL, 1,
			VERDICT_VALID, LIMIT_AT_MAX);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_OVER, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_MAX, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		// One fault each, then stacked faults where the earliest check wins
		add_row(0, 0, ERR_COOKIE, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_NO_COOKIE, 0);
		add_row(0, 0, ERR_VERSION, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_BAD_VER, 0);
		add_row(0, 0, ERR_TYPE, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_NOT_FIXED, 0);
		add_row(0, 0, ERR_CSUM, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_BAD_CSUM, 0);
		add_row(0, 0, ERR_VERSION | ERR_TYPE | ERR_CSUM, FILL_RND, SZ_MAX, 1, FULL, 1,
			VERDICT_BAD_VER, 0);
		add_row(0, 0, ERR_TYPE | ERR_CSUM, FILL_RND, SZ_MAX, 1, FULL, 1,
			VERDICT_NOT_FIXED, 0);
		add_row(0, 0, ERR_CSUM, FILL_RND, SZ_MAX, 1, FULL, 1, VERDICT_BAD_CSUM, 0);
		// Extreme byte values as background, smallest and largest byte sums
		add_row(0, 0, ERR_NONE, FILL_ZERO, SZ_ZERO, 1, FULL, 1, VERDICT_VALID, 0);
		add_row(0, 0, ERR_NONE, FILL_ONES, SZ_LIMIT, 1, FULL, 1,
			VERDICT_VALID, LIMIT_AT_MAX);
		add_row(0, 0, ERR_NONE, RAW_ZERO, SZ_ZERO, 1, FULL, 1, VERDICT_NO_COOKIE, 0);
		add_row(0, 0, ERR_NONE, RAW_ONES, SZ_ZERO, 1, FULL, 1, VERDICT_NO_COOKIE, 0);
		// Drop a partial footer with a restart, then lean on the rearm
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_ZERO, 1, 200, 0, VERDICT_VALID, 0);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_LIMIT, 1, FULL, 1,
			VERDICT_VALID, LIMIT_AT_MAX);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_FIT, 0, FULL, 0, VERDICT_VALID, 0);
		// Short file lengths saturate the limit at zero; 1024 leaves a limit of 512
		add_row(1, 0, ERR_NONE, FILL_RND, SZ_ZERO, 1, FULL, 1, VERDICT_VALID, 0);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_OVER, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		add_row(1, 511, ERR_NONE, FILL_RND, SZ_OVER, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		add_row(1, 1024, ERR_NONE, FILL_RND, SZ_LIMIT, 1, FULL, 1, VERDICT_VALID, 512);
		add_row(0, 0, ERR_NONE, FILL_RND, SZ_OVER, 1, FULL, 1, VERDICT_TOO_LARGE, 0);
		add_row(0, 0, ERR_NONE, RAW_RND, SZ_ZERO, 1, FULL, 0, VERDICT_VALID, 0);

		foreach (dir_cases[i]) begin
			row = dir_cases[i];
			if (row.wr_len) begin
				drain_results();
				write_file_length(row.len);
			end
			build_footer(row.errs, row.fill, row.sz);
			typed_armed = row.typed;
			typed_verdict.verdict = row.exp_v;
			typed_verdict.disk_bytes = row.exp_bytes;
			send_footer(row.lead, row.cut);
		end

		// Random phases, each under its own file length; the checker is drained
		// before every write
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			case (ph)
				0: write_file_length(LEN_MAX);
				1: write_file_length({31'($urandom), $urandom});
				2: write_file_length(63'd0);
				3: write_file_length(63'd511);
				4: write_file_length(63'd512);
				5: write_file_length(63'd513 + 63'($urandom_range(100000)));
				6: write_file_length(63'd512 + 63'($urandom));
				default: write_file_length(LEN_MAX);
			endcase
			// Run one phase flat out on both sides
			send_idle_pct = (ph == 1) ? 0 : 12;
			recv_idle_pct = (ph == 1) ? 0 : 12;
			// Hold the result side long enough to back the input up
			if (ph == 4)
				hold_off_req = 1'b1;
			repeat (FOOTERS_PER_PHASE)
				random_footer_slot();
		end

		drain_results();
		if (pending_verdicts.size() != 0) begin
			$error("%0d footer verdicts never arrived", pending_verdicts.size());
			fail_cnt++;
		end

		$display("Sent %0d footer bytes, checked %0d verdicts over %0d file-length writes",
			bytes_sent, results_seen, len_settings);
		$display("Verdicts: valid %0d, no cookie %0d, bad version %0d, not fixed %0d, %s%0d, %s%0d",
			verdict_hits[VERDICT_VALID], verdict_hits[VERDICT_NO_COOKIE],
			verdict_hits[VERDICT_BAD_VER], verdict_hits[VERDICT_NOT_FIXED],
			"bad checksum ", verdict_hits[VERDICT_BAD_CSUM],
			"too large ", verdict_hits[VERDICT_TOO_LARGE]);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
